### rtl/dhcp_snooping_binding_table_defines.svh
// Assertion macros for the binding table RTL.
`ifndef DHCP_SNOOPING_BINDING_TABLE_DEFINES_SVH
`define DHCP_SNOOPING_BINDING_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define DSBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define DSBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dsbt_pkg.sv
`default_nettype none

package dsbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_AGE    = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_VLAN  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [11:0] VLAN_NONE  = 12'd0;
  localparam logic [11:0] VLAN_LIMIT = 12'd4095;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] mac_addr;
    logic [31:0] ip_addr;
    logic [31:0] lease_secs;
    logic [31:0] expiry_secs;
    logic [11:0] vlan;
    logic [31:0] now_secs;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [47:0]        found_mac;
    logic [31:0]        found_lease;
    logic [31:0]        found_expiry;
    logic [COUNT_W-1:0] removed_count;
  } rsp_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [11:0] vlan;
    logic [31:0] lease;
    logic [31:0] expiry;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic key_hit;
    logic newer;
    logic expired;
  } cmp_t;

endpackage

`default_nettype wire

### rtl/dsbt_entry_ram.sv
`default_nettype none

module dsbt_entry_ram (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [dsbt_pkg::IDX_W-1:0] wr_addr,
  input  wire dsbt_pkg::entry_t          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [dsbt_pkg::IDX_W-1:0] rd_addr,
  output dsbt_pkg::entry_t               rd_data
);

  dsbt_pkg::entry_t mem [dsbt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/dsbt_cmp_unit.sv
`default_nettype none

module dsbt_cmp_unit (
  input  wire dsbt_pkg::entry_t entry,
  input  wire logic [31:0]      key_ip,
  input  wire logic [11:0]      key_vlan,
  input  wire logic [31:0]      now_secs,
  input  wire logic [31:0]      next_stamp,
  input  wire logic [31:0]      best_age,
  output dsbt_pkg::cmp_t        cmp,
  output logic [31:0]           age
);

  // Age counts inserts since this entry, modulo 2^32, so a smaller age is newer.
  assign age         = next_stamp - entry.stamp;
  assign cmp.key_hit = (entry.ip == key_ip) && (entry.vlan == key_vlan);
  assign cmp.newer   = age < best_age;
  assign cmp.expired = entry.expiry <= now_secs;

endmodule

`default_nettype wire

### rtl/dhcp_snooping_binding_table.sv
// DHCP snooping binding table with 64 slots held in a single-port-read entry RAM.
// One request is handled at a time. An insert with VLAN 0 or 4095, or an unused
// kind, answers without a walk. An insert walks the slot valid bits from slot 0 and
// answers once it reaches the lowest free slot, or after the last slot when the table
// is full. Lookup, delete, clear and age tick read every slot through the RAM read
// port, one per cycle, and answer after the walk. The next request can be accepted
// once the response is loaded. A new request is taken while the previous response
// still waits to be accepted; if that response is still waiting when the next one is
// ready, the block holds until it is taken.
`default_nettype none

`include "dhcp_snooping_binding_table_defines.svh"

module dhcp_snooping_binding_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire dsbt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output dsbt_pkg::rsp_t      rsp
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_WALK    = 5'b00010,
    ST_DRAIN   = 5'b00100,
    ST_RESOLVE = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  localparam logic [dsbt_pkg::IDX_W-1:0] LAST_IDX =
    dsbt_pkg::IDX_W'(dsbt_pkg::TABLE_DEPTH - 1);

  state_t                        state;
  dsbt_pkg::req_t                cur;
  dsbt_pkg::rsp_t                res;
  logic [dsbt_pkg::TABLE_DEPTH-1:0] slot_valid;
  logic [31:0]                   next_stamp;
  logic [dsbt_pkg::IDX_W-1:0]    cnt;
  logic                          pend;
  logic                          pvalid;
  logic [dsbt_pkg::IDX_W-1:0]    pidx;
  logic                          best_found;
  logic [31:0]                   best_age;
  logic [dsbt_pkg::IDX_W-1:0]    best_idx;
  logic [47:0]                   best_mac;
  logic [31:0]                   best_lease;
  logic [31:0]                   best_expiry;
  logic [dsbt_pkg::COUNT_W-1:0]  removed;

  logic                          is_insert;
  logic                          is_clear;
  logic                          is_key_op;
  logic                          bad_vlan;
  logic                          load_rsp;
  logic                          wr_en;
  logic                          rd_en;
  dsbt_pkg::entry_t              wr_data;
  dsbt_pkg::entry_t              rd_data;
  dsbt_pkg::cmp_t                cmp;
  logic [31:0]                   age;
  logic                          take_best;
  logic                          drop_slot;

  assign req_ready = (state == ST_IDLE);
  assign is_insert = (cur.kind == dsbt_pkg::KIND_INSERT);
  assign is_clear  = (cur.kind == dsbt_pkg::KIND_CLEAR);
  assign is_key_op = (cur.kind == dsbt_pkg::KIND_LOOKUP) ||
                     (cur.kind == dsbt_pkg::KIND_DELETE);
  assign bad_vlan  = (req.vlan == dsbt_pkg::VLAN_NONE) ||
                     (req.vlan == dsbt_pkg::VLAN_LIMIT);
  assign load_rsp  = (state == ST_FINISH) && (!rsp_valid || rsp_ready);

  assign wr_en   = (state == ST_WALK) && is_insert && !slot_valid[cnt];
  assign rd_en   = (state == ST_WALK) && !is_insert;
  assign wr_data = '{mac: cur.mac_addr, ip: cur.ip_addr, vlan: cur.vlan,
                     lease: cur.lease_secs, expiry: cur.expiry_secs,
                     stamp: next_stamp};

  dsbt_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  dsbt_cmp_unit u_cmp (
    .entry      (rd_data),
    .key_ip     (cur.ip_addr),
    .key_vlan   (cur.vlan),
    .now_secs   (cur.now_secs),
    .next_stamp (next_stamp),
    .best_age   (best_age),
    .cmp        (cmp),
    .age        (age)
  );

  // The slot read last cycle is judged while the next one is being read.
  assign take_best = pend && pvalid && is_key_op && cmp.key_hit &&
                     (!best_found || cmp.newer);
  assign drop_slot = pend && pvalid && !is_key_op && (is_clear || cmp.expired);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      next_stamp <= '0;
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur        <= req;
            cnt        <= '0;
            best_found <= 1'b0;
            removed    <= '0;
            res        <= '{status: (req.kind == dsbt_pkg::KIND_INSERT && bad_vlan) ?
                                    dsbt_pkg::STAT_BAD_VLAN : dsbt_pkg::STAT_OK,
                            found: 1'b0, found_mac: '0, found_lease: '0,
                            found_expiry: '0, removed_count: '0};
            case (req.kind) inside
              dsbt_pkg::KIND_INSERT: begin
                if (bad_vlan) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_WALK;
                end
              end
              dsbt_pkg::KIND_LOOKUP, dsbt_pkg::KIND_DELETE,
              dsbt_pkg::KIND_CLEAR, dsbt_pkg::KIND_AGE: begin
                state <= ST_WALK;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_WALK: begin
          cnt <= cnt + 1'b1;
          if (is_insert) begin
            if (!slot_valid[cnt]) begin
              slot_valid[cnt] <= 1'b1;
              next_stamp      <= next_stamp + 32'd1;
              state           <= ST_FINISH;
            end else if (cnt == LAST_IDX) begin
              res.status <= dsbt_pkg::STAT_FULL;
              state      <= ST_FINISH;
            end
          end else begin
            pend   <= 1'b1;
            pvalid <= slot_valid[cnt];
            pidx   <= cnt;
            if (cnt == LAST_IDX) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          pend  <= 1'b0;
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          if (is_key_op) begin
            if (best_found) begin
              res.found        <= 1'b1;
              res.found_mac    <= best_mac;
              res.found_lease  <= best_lease;
              res.found_expiry <= best_expiry;
              if (cur.kind == dsbt_pkg::KIND_DELETE) begin
                slot_valid[best_idx] <= 1'b0;
              end
            end else begin
              res.status <= dsbt_pkg::STAT_NOT_FOUND;
            end
          end else begin
            res.removed_count <= removed;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (load_rsp) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (take_best) begin
        best_found  <= 1'b1;
        best_age    <= age;
        best_idx    <= pidx;
        best_mac    <= rd_data.mac;
        best_lease  <= rd_data.lease;
        best_expiry <= rd_data.expiry;
      end
      if (drop_slot) begin
        slot_valid[pidx] <= 1'b0;
        if (removed != dsbt_pkg::COUNT_MAX) begin
          removed <= removed + 1'b1;
        end
      end
    end
  end

  `DSBT_ASSERT_NXT(a_stamp_step, wr_en, next_stamp == 32'($past(next_stamp) + 32'd1), "stamp did not advance on insert")
  `DSBT_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid), $past(state == ST_FINISH), "response loaded outside finish")
  `DSBT_ASSERT_IMP(a_pend_in_walk, pend, state == ST_WALK || state == ST_DRAIN, "slot compare pending outside the walk")
  `DSBT_ASSERT_IMP(a_no_rw_mix, wr_en, !rd_en && !pend, "entry write during a read walk")

endmodule

`default_nettype wire

### test/binding_table_checker.sv
`timescale 1ns / 100ps

module binding_table_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  dsbt_pkg::req_t   req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  dsbt_pkg::rsp_t   rsp,
  output int               mismatch_count,
  output int               pending_count
);

  import dsbt_pkg::*;

  // Shadow copy of the binding table.
  logic        bound_valid [TABLE_DEPTH];
  entry_t      bound_entry [TABLE_DEPTH];
  logic [31:0] insert_stamp;

  rsp_t        answer_queue [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic predict_answer(input req_t r, output rsp_t a);
    int          slot;
    int          i;
    logic [31:0] age;
    logic [31:0] best_age;
    entry_t      e;
    a        = '0;
    slot     = -1;
    best_age = '0;
    case (r.kind)
      KIND_INSERT: begin
        if (r.vlan == VLAN_NONE || r.vlan == VLAN_LIMIT) begin
          a.status = STAT_BAD_VLAN;
        end else begin
          // Lowest free slot; no duplicate check.
          for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!bound_valid[i]) slot = i;
          end
          if (slot < 0) begin
            a.status = STAT_FULL;
          end else begin
            e.mac    = r.mac_addr;
            e.ip     = r.ip_addr;
            e.vlan   = r.vlan;
            e.lease  = r.lease_secs;
            e.expiry = r.expiry_secs;
            e.stamp  = insert_stamp;
            bound_entry[slot] = e;
            bound_valid[slot] = 1'b1;
            insert_stamp      = insert_stamp + 32'd1;
          end
        end
      end
      KIND_LOOKUP, KIND_DELETE: begin
        // The newest match has the smallest stamp distance; ties keep the lower slot.
        for (i = 0; i < TABLE_DEPTH; i++) begin
          age = insert_stamp - bound_entry[i].stamp;
          if (bound_valid[i] && bound_entry[i].ip == r.ip_addr &&
              bound_entry[i].vlan == r.vlan && (slot < 0 || age < best_age)) begin
            slot     = i;
            best_age = age;
          end
        end
        if (slot < 0) begin
          a.status = STAT_NOT_FOUND;
        end else begin
          a.found        = 1'b1;
          a.found_mac    = bound_entry[slot].mac;
          a.found_lease  = bound_entry[slot].lease;
          a.found_expiry = bound_entry[slot].expiry;
          if (r.kind == KIND_DELETE) bound_valid[slot] = 1'b0;
        end
      end
      KIND_CLEAR, KIND_AGE: begin
        for (i = 0; i < TABLE_DEPTH; i++) begin
          if (bound_valid[i] &&
              (r.kind == KIND_CLEAR || bound_entry[i].expiry <= r.now_secs)) begin
            bound_valid[i] = 1'b0;
            if (a.removed_count != COUNT_MAX) a.removed_count = a.removed_count + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    int   i;
    if (rst) begin
      for (i = 0; i < TABLE_DEPTH; i++) bound_valid[i] = 1'b0;
      insert_stamp = '0;
      answer_queue.delete();
    end else begin
      // A response accepted here always belongs to an earlier request.
      if (rsp_valid && rsp_ready) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: response expected none actual %h", $time, rsp);
          mismatch_count++;
        end else begin
          want = answer_queue.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("found", want.found, rsp.found);
          check_field("found_mac", want.found_mac, rsp.found_mac);
          check_field("found_lease", want.found_lease, rsp.found_lease);
          check_field("found_expiry", want.found_expiry, rsp.found_expiry);
          check_field("removed_count", want.removed_count, rsp.removed_count);
        end
      end
      if (req_valid && req_ready) begin
        predict_answer(req, want);
        answer_queue.push_back(want);
      end
    end
    pending_count <= answer_queue.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import dsbt_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int IDLE_PERCENT = 31;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 100;
  localparam int KEY_POOL     = 16;
  localparam int STEADY_PHASE = 4;

  localparam logic [2:0]  KIND_SPARE      = KIND_AGE + 3'd1;
  localparam logic [2:0]  KIND_SPARE_LAST = '1;
  localparam logic [31:0] DUP_IP          = 32'h0A00_0001;
  localparam logic [11:0] DUP_VLAN        = 12'd100;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int   mismatch_count;
  int   pending_count;
  logic steady        = 1'b0;
  int   requests_sent = 0;
  int   idle_cycles   = 0;

  logic [31:0] clock_secs;
  logic [31:0] pool_ip   [KEY_POOL];
  logic [11:0] pool_vlan [KEY_POOL];

  dhcp_snooping_binding_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  binding_table_checker table_check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  function automatic req_t fresh_req(input logic [2:0] kind);
    req_t r;
    r.kind        = kind;
    r.mac_addr    = {16'($urandom), $urandom};
    r.ip_addr     = $urandom;
    r.lease_secs  = $urandom;
    r.expiry_secs = $urandom;
    r.vlan        = 12'($urandom);
    r.now_secs    = $urandom;
    return r;
  endfunction

  function automatic logic [2:0] pick_kind();
    int w;
    w = $urandom_range(99);
    if (w < 38) return KIND_INSERT;
    else if (w < 62) return KIND_LOOKUP;
    else if (w < 80) return KIND_DELETE;
    else if (w < 89) return KIND_AGE;
    else if (w < 92) return KIND_CLEAR;
    else return 3'($urandom_range(KIND_SPARE, KIND_SPARE_LAST));
  endfunction

  // Valid is lowered here only when a gap is taken, so back-to-back requests keep it high.
  task automatic send_request(input req_t r);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (r.kind <= KIND_AGE) requests_sent++;
  endtask

  task automatic drain_answers();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic send_keyed(input logic [2:0] kind, input logic [31:0] ip,
                            input logic [11:0] vlan, input logic [31:0] expiry,
                            input logic [31:0] now);
    req_t r;
    r             = fresh_req(kind);
    r.ip_addr     = ip;
    r.vlan        = vlan;
    r.expiry_secs = expiry;
    r.now_secs    = now;
    send_request(r);
  endtask

  // Keys mostly come from a small pool so that lookups hit and duplicates pile up.
  task automatic send_op(input logic [2:0] kind);
    req_t r;
    int   k;
    r = fresh_req(kind);
    if ($urandom_range(99) < 85) begin
      k         = $urandom_range(KEY_POOL - 1);
      r.ip_addr = pool_ip[k];
      r.vlan    = pool_vlan[k];
    end
    if ($urandom_range(99) < 4) r.vlan = $urandom_range(1) ? VLAN_NONE : VLAN_LIMIT;
    case ($urandom_range(19))
      0:       r.expiry_secs = '0;
      1:       r.expiry_secs = '1;
      default: r.expiry_secs = clock_secs + $urandom_range(400);
    endcase
    case ($urandom_range(39))
      0:       r.now_secs = '0;
      1:       r.now_secs = '1;
      default: r.now_secs = clock_secs + $urandom_range(100);
    endcase
    if (kind == KIND_AGE) clock_secs = clock_secs + $urandom_range(20, 120);
    send_request(r);
  endtask

  initial begin : stimulus
    req_t       r;
    logic [2:0] spare;
    int         k;
    int         n;
    int         phase;
    int         roll;

    clock_secs = $urandom;
    for (k = 0; k < KEY_POOL; k++) begin
      pool_ip[k]   = $urandom;
      pool_vlan[k] = 12'($urandom_range(1, 4094));
    end
    pool_vlan[0] = 12'd1;
    pool_vlan[1] = 12'd4094;
    pool_ip[2]   = '0;
    pool_ip[3]   = '1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then the VLAN limits and the field extremes.
    send_keyed(KIND_LOOKUP, '1, 12'd1, '0, '0);
    send_keyed(KIND_DELETE, '0, 12'd4094, '0, '0);
    send_keyed(KIND_CLEAR, '0, 12'd1, '0, '0);
    send_keyed(KIND_INSERT, DUP_IP, VLAN_NONE, '1, '0);
    send_keyed(KIND_INSERT, DUP_IP, VLAN_LIMIT, '1, '0);
    r      = '1;
    r.kind = KIND_INSERT;
    r.vlan = 12'd1;
    send_request(r);
    r      = '0;
    r.kind = KIND_INSERT;
    r.vlan = 12'd4094;
    send_request(r);
    for (n = 1; n <= 3; n++) send_keyed(KIND_INSERT, DUP_IP, DUP_VLAN, 32'(n * 10), '0);
    send_keyed(KIND_LOOKUP, '1, 12'd1, '0, '0);
    send_keyed(KIND_LOOKUP, '0, 12'd4094, '0, '0);
    send_keyed(KIND_LOOKUP, '0, VLAN_NONE, '0, '0);
    send_keyed(KIND_LOOKUP, '1, VLAN_LIMIT, '0, '0);

    // Newest duplicate wins, and a reused slot still counts as newest.
    send_keyed(KIND_LOOKUP, DUP_IP, DUP_VLAN, '0, '0);
    send_keyed(KIND_DELETE, DUP_IP, DUP_VLAN, '0, '0);
    send_keyed(KIND_LOOKUP, DUP_IP, DUP_VLAN, '0, '0);
    send_keyed(KIND_INSERT, DUP_IP, DUP_VLAN, 32'd40, '0);
    send_keyed(KIND_DELETE, DUP_IP, DUP_VLAN, '0, '0);

    // Expiry equal to now is removed.
    send_keyed(KIND_AGE, '0, 12'd1, '0, '0);
    send_keyed(KIND_AGE, '0, 12'd1, '0, 32'd20);
    send_keyed(KIND_AGE, '0, 12'd1, '0, '1);
    send_keyed(KIND_INSERT, $urandom, 12'd2, $urandom, '0);
    send_keyed(KIND_INSERT, $urandom, 12'd3, $urandom, '0);
    send_keyed(KIND_CLEAR, '0, 12'd1, '0, '0);
    for (spare = KIND_SPARE; spare != KIND_INSERT; spare++) begin
      send_keyed(spare, $urandom, 12'($urandom), $urandom, $urandom);
    end
    drain_answers();

    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      phase++;
      steady <= (phase == STEADY_PHASE);
      roll = $urandom_range(9);
      if (roll < 5) begin
        repeat (40) send_op(pick_kind());
      end else if (roll < 8) begin
        // Run the table into full, probe it, then empty it partly or wholly.
        repeat (TABLE_DEPTH + 4) send_op(KIND_INSERT);
        repeat (12) send_op($urandom_range(1) ? KIND_LOOKUP : KIND_DELETE);
        send_op($urandom_range(1) ? KIND_CLEAR : KIND_AGE);
      end else begin
        repeat (24) begin
          send_op(KIND_INSERT);
          if ($urandom_range(3) == 0) send_op(KIND_AGE);
          if ($urandom_range(3) == 0) send_op(KIND_LOOKUP);
        end
      end
      if (phase == 2 || $urandom_range(3) == 0) drain_answers();
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
